### rtl/shamd_pkg.sv
`default_nettype none

package shamd_pkg;

    localparam int QUEUE_DEPTH = 2;

    typedef logic [15:0][31:0] t_words;

    typedef struct packed {
        logic   last;
        t_words words;
    } t_blk;

    localparam logic [7:0][31:0] HASH_IV = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        round_k = k;
    endfunction

endpackage

`default_nettype wire

### rtl/shamd_if.sv
`default_nettype none

interface shamd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;

    modport source (output valid, data_byte, has_byte, end_of_message, input ready);
    modport sink (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface shamd_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

`default_nettype wire

### rtl/shamd_front.sv
`default_nettype none

module shamd_front
    import shamd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    shamd_in_if.sink   i_item,
    output t_blk       o_blk,
    output logic       o_blk_valid,
    input  wire logic  i_blk_ready
);

    localparam logic [1:0] S_IN  = 2'd0;
    localparam logic [1:0] S_PAD = 2'd1;
    localparam logic [1:0] S_LEN = 2'd2;

    logic [1:0]  r_state, n_state;
    logic        r_push, n_push;
    logic        r_push_last, n_push_last;
    logic        r_pad_first, n_pad_first;
    logic [5:0]  r_pos, n_pos;
    logic [63:0] r_cnt, n_cnt;
    t_words      r_buf, n_buf;

    logic        accept;
    logic        put_en;
    logic [7:0]  put_val;
    logic [3:0]  wi;

    assign i_item.ready = (r_state == S_IN) && !r_push;
    assign accept       = i_item.valid && i_item.ready;
    assign wi           = r_pos[5:2];

    assign o_blk_valid  = r_push;
    assign o_blk.last   = r_push_last;
    assign o_blk.words  = r_buf;

    always_comb begin
        n_state     = r_state;
        n_push      = r_push;
        n_push_last = r_push_last;
        n_pad_first = r_pad_first;
        n_pos       = r_pos;
        n_cnt       = r_cnt;
        n_buf       = r_buf;
        put_en      = 1'b0;
        put_val     = 8'h00;

        if (r_push && i_blk_ready) begin
            n_push = 1'b0;
        end

        case (r_state)
            S_IN: begin
                if (accept) begin
                    put_en  = i_item.has_byte;
                    put_val = i_item.data_byte;
                    if (i_item.has_byte) begin
                        n_cnt = r_cnt + 64'd8;
                    end
                    if (i_item.end_of_message) begin
                        n_state     = S_PAD;
                        n_pad_first = 1'b1;
                    end
                end
            end
            S_PAD: begin
                if (!r_push) begin
                    put_en      = 1'b1;
                    put_val     = r_pad_first ? PAD_BYTE : 8'h00;
                    n_pad_first = 1'b0;
                    if (r_pos == 6'd55) begin
                        n_state = S_LEN;
                    end
                end
            end
            S_LEN: begin
                if (!r_push) begin
                    n_buf[14]   = r_cnt[63:32];
                    n_buf[15]   = r_cnt[31:0];
                    n_push      = 1'b1;
                    n_push_last = 1'b1;
                    n_cnt       = '0;
                    n_pos       = '0;
                    n_state     = S_IN;
                end
            end
            default: begin
                n_state = S_IN;
            end
        endcase

        if (put_en) begin
            case (r_pos[1:0])
                2'd0: n_buf[wi] = {put_val, 24'h0};
                2'd1: n_buf[wi] = {r_buf[wi][31:24], put_val, r_buf[wi][15:0]};
                2'd2: n_buf[wi] = {r_buf[wi][31:16], put_val, r_buf[wi][7:0]};
                default: n_buf[wi] = {r_buf[wi][31:8], put_val};
            endcase
            n_pos = r_pos + 6'd1;
            if (r_pos == 6'd63) begin
                n_push      = 1'b1;
                n_push_last = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IN;
            r_push      <= 1'b0;
            r_push_last <= 1'b0;
            r_pad_first <= 1'b0;
            r_pos       <= '0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_push      <= n_push;
            r_push_last <= n_push_last;
            r_pad_first <= n_pad_first;
            r_pos       <= n_pos;
            r_cnt       <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
    end

endmodule

`default_nettype wire

### rtl/shamd_queue.sv
`default_nettype none

module shamd_queue
    import shamd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_blk  i_blk,
    input  wire logic  i_valid,
    output logic       o_ready,
    output t_blk       o_blk,
    output logic       o_valid,
    input  wire logic  i_ready
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_blk          r_mem [DEPTH];
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          push, pop;

    assign o_ready = r_cnt < CW'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_blk   = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (push) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
        end
        if (pop) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
        end
        if (push && !pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (pop && !push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_blk;
        end
    end

endmodule

`default_nettype wire

### rtl/shamd_back.sv
`default_nettype none

module shamd_back
    import shamd_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_blk   i_blk,
    input  wire logic   i_blk_valid,
    output logic        o_blk_ready,
    shamd_out_if.source o_digest
);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_RND  = 2'd1;
    localparam logic [1:0] B_ADD  = 2'd2;
    localparam logic [1:0] B_OUT  = 2'd3;

    logic [1:0]  r_state;
    logic [5:0]  r_rnd;
    logic        r_last;
    logic [2:0]  r_idx;
    logic [31:0] r_hash [8];
    logic [31:0] r_v [8];
    logic [31:0] r_w [16];

    logic [31:0] big_s0, big_s1, ch, maj, t1, t2;
    logic [31:0] sm_s0, sm_s1, w_new;
    logic        load, out_take;

    assign o_blk_ready = r_state == B_IDLE;
    assign load        = i_blk_valid && o_blk_ready;

    assign o_digest.valid       = r_state == B_OUT;
    assign o_digest.digest_word = r_hash[r_idx];
    assign o_digest.word_index  = r_idx;
    assign o_digest.last_word   = r_idx == 3'd7;
    assign out_take             = o_digest.valid && o_digest.ready;

    always_comb begin
        big_s1 = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
        ch     = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        t1     = r_v[7] + big_s1 + ch + round_k(r_rnd) + r_w[0];
        big_s0 = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
        maj    = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t2     = big_s0 + maj;
        sm_s0  = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        sm_s1  = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_new  = r_w[0] + sm_s0 + r_w[9] + sm_s1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_rnd   <= '0;
            r_last  <= 1'b0;
            r_idx   <= '0;
            for (int i = 0; i < 8; i++) begin
                r_hash[i] <= HASH_IV[i];
            end
        end else begin
            case (r_state)
                B_IDLE: begin
                    if (load) begin
                        r_last  <= i_blk.last;
                        r_rnd   <= '0;
                        r_state <= B_RND;
                    end
                end
                B_RND: begin
                    r_rnd <= r_rnd + 6'd1;
                    if (r_rnd == 6'd63) begin
                        r_state <= B_ADD;
                    end
                end
                B_ADD: begin
                    for (int i = 0; i < 8; i++) begin
                        r_hash[i] <= r_hash[i] + r_v[i];
                    end
                    r_idx   <= '0;
                    r_state <= r_last ? B_OUT : B_IDLE;
                end
                B_OUT: begin
                    if (out_take) begin
                        r_idx <= r_idx + 3'd1;
                        if (r_idx == 3'd7) begin
                            for (int i = 0; i < 8; i++) begin
                                r_hash[i] <= HASH_IV[i];
                            end
                            r_state <= B_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            for (int i = 0; i < 16; i++) begin
                r_w[i] <= i_blk.words[i];
            end
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= r_hash[i];
            end
        end else if (r_state == B_RND) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[15] <= w_new;
            r_v[7]  <= r_v[6];
            r_v[6]  <= r_v[5];
            r_v[5]  <= r_v[4];
            r_v[4]  <= r_v[3] + t1;
            r_v[3]  <= r_v[2];
            r_v[2]  <= r_v[1];
            r_v[1]  <= r_v[0];
            r_v[0]  <= t1 + t2;
        end
    end

endmodule

`default_nettype wire

### rtl/sha256_message_digest_core.sv
`default_nettype none

// SHA-256 over a byte stream, at most one byte per item. The front packs
// bytes into 512-bit blocks at one item per cycle while no full block waits
// to be handed to the QDEPTH-deep block queue (QUEUE_DEPTH by default). The
// back runs one compression round per cycle; each block passes through load,
// 64 rounds and hash update, and the back takes no new block until the last
// one is done, so the sustained rate is set by the round unit. The end item
// pads one byte per cycle while no full block waits, up to the length field,
// then places the length; when the length does not fit, the padding fills the
// block and one more block follows. The eight digest words then leave one per
// cycle while the sink is ready, word 0 first. After the last word the hash
// state is back at its initial value for the next message.

module sha256_message_digest_core
    import shamd_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    shamd_in_if.sink    i_item,
    shamd_out_if.source o_digest
);

    t_blk f_blk, q_blk;
    logic f_valid, f_ready;
    logic q_valid, q_ready;

    shamd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .o_blk       (f_blk),
        .o_blk_valid (f_valid),
        .i_blk_ready (f_ready)
    );

    shamd_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_blk   (f_blk),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .o_blk   (q_blk),
        .o_valid (q_valid),
        .i_ready (q_ready)
    );

    shamd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_blk       (q_blk),
        .i_blk_valid (q_valid),
        .o_blk_ready (q_ready),
        .o_digest    (o_digest)
    );

endmodule

`default_nettype wire

### verif/sha256_message_digest_core_test.sv
`timescale 1ns / 100ps

module sha256_message_digest_core_test;
    import shamd_pkg::*;

    localparam int RANDOM_ITEMS = 148;
    localparam int TAIL_ITEMS   = 30;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 300;
    localparam int TIMEOUT_NS   = 1_000_000;

    localparam logic [0:63][31:0] ROUND_CONST = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct {
        logic [7:0] data;
        logic       has;
        logic       eom;
    } t_byte_item;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_word;

    logic i_clk;
    logic i_rst_n;

    shamd_in_if  in_if ();
    shamd_out_if out_if ();

    sha256_message_digest_core u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (in_if),
        .o_digest (out_if)
    );

    t_byte_item   byte_items[$];
    t_digest_word pending_words[$];
    t_digest_word next_word;

    logic [31:0] hash_state [8];
    logic [7:0]  block_bytes [64];
    int          block_fill;
    logic [63:0] bit_length;

    int   error_count;
    int   accepted_items;
    int   directed_total;
    int   counted_items;
    int   send_gap;
    int   recv_gap;
    logic bursts_on;
    logic hold_sink;

    always #1 i_clk = ~i_clk;

    function automatic logic [31:0] rot_right(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void hash_clear();
        for (int i = 0; i < 8; i++) hash_state[i] = HASH_IV[i];
        for (int i = 0; i < 64; i++) block_bytes[i] = 8'h00;
        block_fill = 0;
        bit_length = 64'd0;
    endfunction

    function automatic void hash_compress();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] s0, s1, ch, maj, t1, t2;
        for (int i = 0; i < 16; i++) begin
            w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
        end
        for (int i = 16; i < 64; i++) begin
            s0 = rot_right(w[i-15], 7) ^ rot_right(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = rot_right(w[i-2], 17) ^ rot_right(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        for (int i = 0; i < 8; i++) v[i] = hash_state[i];
        for (int r = 0; r < 64; r++) begin
            s1 = rot_right(v[4], 6) ^ rot_right(v[4], 11) ^ rot_right(v[4], 25);
            ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
            t1 = v[7] + s1 + ch + ROUND_CONST[r] + w[r];
            s0 = rot_right(v[0], 2) ^ rot_right(v[0], 13) ^ rot_right(v[0], 22);
            maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
            t2 = s0 + maj;
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_state[i] = hash_state[i] + v[i];
    endfunction

    function automatic void hash_place_byte(logic [7:0] b);
        block_bytes[block_fill] = b;
        block_fill++;
        if (block_fill == 64) begin
            hash_compress();
            block_fill = 0;
        end
    endfunction

    function automatic void hash_finish_message();
        logic [63:0] msg_len;
        t_digest_word dw;
        msg_len = bit_length;
        hash_place_byte(PAD_BYTE);
        while (block_fill != 56) hash_place_byte(8'h00);
        for (int i = 0; i < 8; i++) block_bytes[56+i] = msg_len[63-8*i -: 8];
        hash_compress();
        for (int i = 0; i < 8; i++) begin
            dw.word = hash_state[i];
            dw.index = 3'(i);
            dw.last = (i == 7);
            pending_words.push_back(dw);
        end
        hash_clear();
    endfunction

    function automatic void hash_predict_item(logic [7:0] data, logic has, logic eom);
        if (has) begin
            hash_place_byte(data);
            bit_length = bit_length + 64'd8;
        end
        if (eom) hash_finish_message();
    endfunction

    function automatic void add_item(logic [7:0] data, logic has, logic eom);
        t_byte_item it;
        it.data = data;
        it.has = has;
        it.eom = eom;
        byte_items.push_back(it);
        counted_items++;
    endfunction

    // random bytes with stray idle items, end on the last byte or a bare end marker
    function automatic void add_message(int len, bit end_on_byte);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0) add_item(8'($urandom), 1'b0, 1'b0);
            add_item(8'($urandom), 1'b1, (end_on_byte && i == len - 1));
        end
        if (!end_on_byte || len == 0) add_item(8'($urandom), 1'b0, 1'b1);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        error_count++;
        $display("%0t: %s mismatch, got %h, expected %h", $time, what, got, want);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            bursts_on <= 1'b1;
        end else begin
            if (in_if.valid && in_if.ready) begin
                hash_predict_item(in_if.data_byte, in_if.has_byte, in_if.end_of_message);
                void'(byte_items.pop_front());
                accepted_items++;
                if (bursts_on && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 15);
            end
            bursts_on <= (byte_items.size() > TAIL_ITEMS);
            if (!in_if.valid || in_if.ready) begin
                if (send_gap > 0) begin
                    in_if.valid <= 1'b0;
                    send_gap--;
                end else if (byte_items.size() > 0) begin
                    in_if.valid <= 1'b1;
                    in_if.data_byte <= byte_items[0].data;
                    in_if.has_byte <= byte_items[0].has;
                    in_if.end_of_message <= byte_items[0].eom;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (pending_words.size() == 0) begin
                    report_mismatch("unexpected digest word", out_if.digest_word, 32'h0);
                end else begin
                    next_word = pending_words.pop_front();
                    if (out_if.digest_word !== next_word.word) begin
                        report_mismatch("digest_word", out_if.digest_word, next_word.word);
                    end
                    if (out_if.word_index !== next_word.index) begin
                        report_mismatch("word_index", 32'(out_if.word_index),
                                        32'(next_word.index));
                    end
                    if (out_if.last_word !== next_word.last) begin
                        report_mismatch("last_word", 32'(out_if.last_word),
                                        32'(next_word.last));
                    end
                end
            end
            if (hold_sink) begin
                out_if.ready <= 1'b0;
            end else if (recv_gap > 0) begin
                out_if.ready <= 1'b0;
                recv_gap--;
            end else begin
                out_if.ready <= 1'b1;
                if (bursts_on && $urandom_range(0, 7) == 0) recv_gap = $urandom_range(1, 15);
            end
        end
    end

    // long sink stall right after the directed items so the block backs up
    initial begin
        hold_sink = 1'b0;
        @(posedge i_clk);
        while (accepted_items < directed_total) @(posedge i_clk);
        hold_sink <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_sink <= 1'b0;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int msg_num;
        int len;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.data_byte = 8'h00;
        in_if.has_byte = 1'b0;
        in_if.end_of_message = 1'b0;
        out_if.ready = 1'b0;
        error_count = 0;
        accepted_items = 0;
        counted_items = 0;
        send_gap = 0;
        recv_gap = 0;
        bursts_on = 1'b1;
        hash_clear();

        // idle item, empty message, single byte extremes, "abc"
        add_item(8'hff, 1'b0, 1'b0);
        add_item(8'h5a, 1'b0, 1'b1);
        add_item(8'h00, 1'b1, 1'b1);
        add_item(8'hff, 1'b1, 1'b1);
        add_item(8'h61, 1'b1, 1'b0);
        add_item(8'h62, 1'b1, 1'b0);
        add_item(8'h63, 1'b1, 1'b1);
        // bytes then a bare end marker, then a second empty message
        add_item(8'h80, 1'b1, 1'b0);
        add_item(8'h7f, 1'b1, 1'b0);
        add_item(8'hc3, 1'b0, 1'b0);
        add_item(8'h00, 1'b0, 1'b1);
        add_item(8'hff, 1'b0, 1'b1);
        directed_total = byte_items.size();
        counted_items = 0;

        // 55 bytes fit the length in one block, 56 need a second one
        msg_num = 0;
        while (counted_items < RANDOM_ITEMS) begin
            if (msg_num == 0) len = 55;
            else if (msg_num == 1) len = 56;
            else if ($urandom_range(0, 7) == 0) len = $urandom_range(57, 72);
            else len = $urandom_range(0, 12);
            add_message(len, $urandom_range(0, 2) != 0);
            msg_num++;
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (byte_items.size() > 0) @(posedge i_clk);
        while (pending_words.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### sha256_message_digest_core.f
rtl/shamd_pkg.sv
rtl/shamd_if.sv
rtl/shamd_front.sv
rtl/shamd_queue.sv
rtl/shamd_back.sv
rtl/sha256_message_digest_core.sv
verif/sha256_message_digest_core_test.sv
